### src/vdss_pkg.sv
// ----------------------------------------------------------------------------
// vdss_pkg
// shared types and constants of the voxel density sphere sculpt core
// ----------------------------------------------------------------------------
package vdss_pkg;

   localparam int MAX_CELLS_DEF = 16;
   localparam int FRAC_BITS_DEF = 8;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      OP_GENERATE = 2'd0,
      OP_SCULPT   = 2'd1,
      OP_READ     = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   localparam logic [2:0] CSR_CELL_COUNT     = 3'd0;
   localparam logic [2:0] CSR_CELL_PITCH     = 3'd1;
   localparam logic [2:0] CSR_CHUNK_EDGE     = 3'd2;
   localparam logic [2:0] CSR_CHUNK_CENTER_X = 3'd3;
   localparam logic [2:0] CSR_CHUNK_CENTER_Y = 3'd4;
   localparam logic [2:0] CSR_CHUNK_CENTER_Z = 3'd5;
   localparam logic [2:0] CSR_BASE_RADIUS    = 3'd6;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] sphere_x;
      logic signed [31:0] sphere_y;
      logic signed [31:0] sphere_z;
      logic [30:0]        sphere_radius;
      logic [4:0]         vertex_x;
      logic [4:0]         vertex_y;
      logic [4:0]         vertex_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] density_out;
      logic [12:0]        changed_count;
      logic               skipped;
   } rsp_type;

endpackage

### src/voxel_density_sphere_sculpt_core.sv
// ----------------------------------------------------------------------------
// voxel_density_sphere_sculpt_core
// signed-distance density grid of one chunk with generate, sphere sculpt, read
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; busy stays high until
// the single result has been shown on rsp_data for one cycle with rsp_valid,
// and the receiver must take it then. a read passes through S_READ and
// S_RDWAIT before S_DONE. a generate visits all (n+1)^3 vertices, each with
// three multiply / add / square / accumulate passes through the one shared
// 31x31 multiplier, then a square root unless an axis distance saturates. a
// sculpt first does one divide-by-pitch walk of up to n steps for each box
// bound, then visits the clipped box: vertices outside the radius skip the
// square root. the grid is a single-port ram; reading a vertex before the
// first generate returns garbage.
// ----------------------------------------------------------------------------
module voxel_density_sphere_sculpt_core #(
   parameter int MAX_CELLS = vdss_pkg::MAX_CELLS_DEF,
   parameter int FRAC_BITS = vdss_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vdss_pkg::req_type req_data,
   output logic             rsp_valid,
   output vdss_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);

   import vdss_pkg::*;

   localparam int SIDE   = MAX_CELLS + 1;
   localparam int DEPTH  = SIDE * SIDE * SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(SIDE);
   localparam int ACC_W  = 31 + IDX_W;
   localparam int D_W    = ACC_W + 3;

   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_R2     = 16'h0002,
      S_SETUP  = 16'h0004,
      S_QLO    = 16'h0008,
      S_QHI    = 16'h0010,
      S_LOAD   = 16'h0020,
      S_MUL    = 16'h0040,
      S_ADD    = 16'h0080,
      S_SQ     = 16'h0100,
      S_ACC    = 16'h0200,
      S_EVAL   = 16'h0400,
      S_ROOT   = 16'h0800,
      S_NEXT   = 16'h1000,
      S_READ   = 16'h2000,
      S_RDWAIT = 16'h4000,
      S_DONE   = 16'h8000
   } state_type;

   // configuration registers
   logic [4:0]         cell_count_ff;
   logic [30:0]        cell_pitch_ff;
   logic [30:0]        chunk_edge_ff;
   logic signed [31:0] cc_ff [3];
   logic [30:0]        base_radius_ff;

   // sequencer state
   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [1:0]         ax_ff, ax_in;
   logic [IDX_W-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [IDX_W-1:0]   st_ff [3];
   logic [IDX_W-1:0]   st_in [3];
   logic [IDX_W-1:0]   en_ff [3];
   logic [IDX_W-1:0]   en_in [3];
   logic signed [D_W-1:0] off_ff [3];
   logic signed [D_W-1:0] off_in [3];
   logic signed [31:0] s_ff [3];
   logic signed [31:0] s_in [3];
   logic [30:0]        r_ff, r_in;
   logic [61:0]        r2_ff, r2_in;
   logic [31:0]        vlo_ff, vlo_in, vhi_ff, vhi_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [30:0]        mag_ff, mag_in;
   logic               sat_ff, sat_in;
   logic [63:0]        sum_ff, sum_in;
   logic [12:0]        cnt_ff, cnt_in;
   logic               skip_ff, skip_in;
   logic [31:0]        dens_ff, dens_in;
   logic               oor_ff, oor_in;

   // shared multiplier
   logic [30:0]        mul_a, mul_b;
   logic [61:0]        mul_ff;

   // combinational helpers
   logic [IDX_W-1:0]   n_c;
   logic [29:0]        half_c;
   logic signed [33:0] cmin_c [3];
   logic signed [33:0] cmax_c [3];
   logic signed [33:0] s34_c, r34_c, spr_c, smr_c, lo_c, hi_c;
   logic               miss_c;
   logic [ACC_W:0]     accp_c;
   logic [IDX_W-1:0]   idx_c;
   logic signed [D_W-1:0] d_c, dabs_c;
   logic [30:0]        rad_c;
   logic [30:0]        dist_c;
   logic signed [32:0] tgt_c;
   logic [ADDR_W-1:0]  addr_c;

   // memory and root unit
   logic               ram_we;
   logic [31:0]        ram_wdata, ram_rdata;
   logic               sq_start, sq_done;
   logic [31:0]        sq_root;

   assign csr_ready = 1'b1;

   // configuration transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_ff  <= 5'd16;
         cell_pitch_ff  <= 31'd256;
         chunk_edge_ff  <= 31'd4096;
         cc_ff[0]       <= '0;
         cc_ff[1]       <= '0;
         cc_ff[2]       <= '0;
         base_radius_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CELL_COUNT:     cell_count_ff  <= csr_data[4:0];
            CSR_CELL_PITCH:     cell_pitch_ff  <= csr_data[30:0];
            CSR_CHUNK_EDGE:     chunk_edge_ff  <= csr_data[30:0];
            CSR_CHUNK_CENTER_X: cc_ff[0]       <= csr_data;
            CSR_CHUNK_CENTER_Y: cc_ff[1]       <= csr_data;
            CSR_CHUNK_CENTER_Z: cc_ff[2]       <= csr_data;
            CSR_BASE_RADIUS:    base_radius_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // chunk box and per-axis setup arithmetic
   always_comb begin
      n_c    = (int'(cell_count_ff) > MAX_CELLS) ? IDX_W'(MAX_CELLS) : IDX_W'(cell_count_ff);
      half_c = chunk_edge_ff[30:1];
      for (int a = 0; a < 3; a++) begin
         cmin_c[a] = 34'(cc_ff[a]) - $signed({4'b0000, half_c});
         cmax_c[a] = 34'(cc_ff[a]) + $signed({4'b0000, half_c});
      end
      s34_c  = 34'(s_ff[ax_ff]);
      r34_c  = $signed({3'b000, r_ff});
      spr_c  = s34_c + r34_c;
      smr_c  = s34_c - r34_c;
      miss_c = (spr_c < cmin_c[ax_ff]) || (smr_c > cmax_c[ax_ff]);
      lo_c   = (smr_c > cmin_c[ax_ff]) ? smr_c : cmin_c[ax_ff];
      hi_c   = (spr_c < cmax_c[ax_ff]) ? spr_c : cmax_c[ax_ff];
      accp_c = {1'b0, acc_ff} + (ACC_W + 1)'(cell_pitch_ff);
      idx_c  = (ax_ff == 2'd0) ? x_ff : ((ax_ff == 2'd1) ? y_ff : z_ff);
      d_c    = D_W'($signed({1'b0, mul_ff[ACC_W-1:0]})) + off_ff[ax_ff];
      dabs_c = d_c[D_W-1] ? -d_c : d_c;
      rad_c  = base_radius_ff & ~((31'd1 << FRAC_BITS) - 31'd1);
      dist_c = (sq_root > SAT_MAX) ? SAT_MAX[30:0] : sq_root[30:0];
      tgt_c  = $signed({1'b0, sq_root}) - $signed({2'b00, r_ff});
      addr_c = ADDR_W'(x_ff) + ADDR_W'(y_ff) * ADDR_W'(SIDE)
             + ADDR_W'(z_ff) * ADDR_W'(SIDE * SIDE);
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_R2: begin
            mul_a = r_ff;
            mul_b = r_ff;
         end
         S_MUL: begin
            mul_a = 31'(idx_c);
            mul_b = cell_pitch_ff;
         end
         S_SQ: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      ax_in     = ax_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      st_in     = st_ff;
      en_in     = en_ff;
      off_in    = off_ff;
      s_in      = s_ff;
      r_in      = r_ff;
      r2_in     = r2_ff;
      vlo_in    = vlo_ff;
      vhi_in    = vhi_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      mag_in    = mag_ff;
      sat_in    = sat_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      skip_in   = skip_ff;
      dens_in   = dens_ff;
      oor_in    = oor_ff;
      ram_we    = 1'b0;
      ram_wdata = '0;
      sq_start  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = req_data.op;
               cnt_in  = '0;
               skip_in = 1'b0;
               dens_in = '0;
               ax_in   = '0;
               case (req_data.op)
                  OP_GENERATE: begin
                     for (int a = 0; a < 3; a++) begin
                        off_in[a] = D_W'(cmin_c[a]);
                        st_in[a]  = '0;
                        en_in[a]  = n_c;
                     end
                     state_in = S_LOAD;
                  end
                  OP_SCULPT: begin
                     s_in[0] = req_data.sphere_x;
                     s_in[1] = req_data.sphere_y;
                     s_in[2] = req_data.sphere_z;
                     r_in    = req_data.sphere_radius;
                     if ((n_c == '0) || (cell_pitch_ff == '0)) begin
                        skip_in  = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_R2;
                     end
                  end
                  OP_READ: begin
                     x_in     = IDX_W'(req_data.vertex_x);
                     y_in     = IDX_W'(req_data.vertex_y);
                     z_in     = IDX_W'(req_data.vertex_z);
                     oor_in   = (int'(req_data.vertex_x) > MAX_CELLS)
                             || (int'(req_data.vertex_y) > MAX_CELLS)
                             || (int'(req_data.vertex_z) > MAX_CELLS);
                     state_in = S_READ;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_R2: state_in = S_SETUP;
         S_SETUP: begin
            if (ax_ff == 2'd0) begin
               r2_in = mul_ff;
            end
            if (miss_c) begin
               skip_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               vlo_in          = 32'(lo_c - cmin_c[ax_ff]);
               vhi_in          = 32'(hi_c - cmin_c[ax_ff]);
               off_in[ax_ff]   = D_W'(cmin_c[ax_ff] - s34_c);
               k_in            = '0;
               acc_in          = '0;
               state_in        = S_QLO;
            end
         end
         // floor of the low bound over the pitch, clamped to n
         S_QLO: begin
            if ((k_ff < n_c) && (accp_c <= (ACC_W + 1)'(vlo_ff))) begin
               acc_in = accp_c[ACC_W-1:0];
               k_in   = k_ff + 1'b1;
            end else begin
               st_in[ax_ff] = k_ff;
               k_in         = '0;
               acc_in       = '0;
               state_in     = S_QHI;
            end
         end
         // ceiling of the high bound over the pitch, clamped to n
         S_QHI: begin
            if ((k_ff < n_c) && ((ACC_W + 1)'(acc_ff) < (ACC_W + 1)'(vhi_ff))) begin
               acc_in = accp_c[ACC_W-1:0];
               k_in   = k_ff + 1'b1;
            end else begin
               en_in[ax_ff] = k_ff;
               if (ax_ff == 2'd2) begin
                  state_in = S_LOAD;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = S_SETUP;
               end
            end
         end
         S_LOAD: begin
            x_in     = st_ff[0];
            y_in     = st_ff[1];
            z_in     = st_ff[2];
            ax_in    = '0;
            sum_in   = '0;
            sat_in   = 1'b0;
            state_in = S_MUL;
         end
         S_MUL: state_in = S_ADD;
         S_ADD: begin
            mag_in = dabs_c[30:0];
            if (op_ff == OP_GENERATE) begin
               if (unsigned'(dabs_c) > D_W'(SAT_MAX)) begin
                  sat_in = 1'b1;
               end
               state_in = S_SQ;
            end else if (unsigned'(dabs_c) > D_W'(r_ff)) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_SQ;
            end
         end
         S_SQ: state_in = S_ACC;
         S_ACC: begin
            sum_in = sum_ff + 64'(mul_ff);
            if (ax_ff == 2'd2) begin
               state_in = S_EVAL;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_EVAL: begin
            if (op_ff == OP_GENERATE) begin
               if (sat_ff) begin
                  ram_we    = 1'b1;
                  ram_wdata = {1'b0, rad_c} - {1'b0, SAT_MAX[30:0]};
                  state_in  = S_NEXT;
               end else begin
                  sq_start = 1'b1;
                  state_in = S_ROOT;
               end
            end else if (sum_ff > {2'b00, r2_ff}) begin
               state_in = S_NEXT;
            end else begin
               sq_start = 1'b1;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            if (sq_done) begin
               if (op_ff == OP_GENERATE) begin
                  ram_we    = 1'b1;
                  ram_wdata = {1'b0, rad_c} - {1'b0, dist_c};
               end else if (tgt_c < $signed({ram_rdata[31], ram_rdata})) begin
                  ram_we    = 1'b1;
                  ram_wdata = tgt_c[31:0];
                  cnt_in    = cnt_ff + 13'd1;
               end
               state_in = S_NEXT;
            end
         end
         // step x fastest, then y, then z
         S_NEXT: begin
            ax_in    = '0;
            sum_in   = '0;
            sat_in   = 1'b0;
            state_in = S_MUL;
            if (x_ff < en_ff[0]) begin
               x_in = x_ff + 1'b1;
            end else begin
               x_in = st_ff[0];
               if (y_ff < en_ff[1]) begin
                  y_in = y_ff + 1'b1;
               end else begin
                  y_in = st_ff[1];
                  if (z_ff < en_ff[2]) begin
                     z_in = z_ff + 1'b1;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_READ: state_in = S_RDWAIT;
         S_RDWAIT: begin
            dens_in  = oor_ff ? 32'd0 : ram_rdata;
            state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff   <= op_in;
      ax_ff   <= ax_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      st_ff   <= st_in;
      en_ff   <= en_in;
      off_ff  <= off_in;
      s_ff    <= s_in;
      r_ff    <= r_in;
      r2_ff   <= r2_in;
      vlo_ff  <= vlo_in;
      vhi_ff  <= vhi_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      mag_ff  <= mag_in;
      sat_ff  <= sat_in;
      sum_ff  <= sum_in;
      cnt_ff  <= cnt_in;
      skip_ff <= skip_in;
      dens_ff <= dens_in;
      oor_ff  <= oor_in;
      mul_ff  <= mul_a * mul_b;
   end

   // density grid
   vdss_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (ram_we),
      .addr  (addr_c),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // shared root unit
   vdss_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sum_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign busy                   = (state_ff != S_IDLE);
   assign rsp_valid              = (state_ff == S_DONE);
   assign rsp_data.density_out   = dens_ff;
   assign rsp_data.changed_count = cnt_ff;
   assign rsp_data.skipped       = skip_ff;

endmodule

### src/vdss_ram.sv
// ----------------------------------------------------------------------------
// vdss_ram
// generic single-port ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
module vdss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4913
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### src/vdss_sqrt.sv
// ----------------------------------------------------------------------------
// vdss_sqrt
// floor square root of a 64-bit value, two radicand bits per cycle
// ----------------------------------------------------------------------------
module vdss_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] rad_ff, rad_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff[33:0], rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = (rem_sh >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[30:0], ge};
         rad_in  = {rad_ff[61:0], 2'b00};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
